### design/lbc3d_pkg.sv
// Shared types and constants for the 3D segment-to-box clipper.
// Holds the input and result word layouts and the config register indexes.
package lbc3d_pkg;

  localparam int NumAxes     = 3;
  localparam int NumDivSteps = 17;
  localparam logic [16:0] TOne = 17'h10000;

  typedef enum logic [2:0] {
    REG_BOX_LO_X = 3'd0,
    REG_BOX_LO_Y = 3'd1,
    REG_BOX_LO_Z = 3'd2,
    REG_BOX_HI_X = 3'd3,
    REG_BOX_HI_Y = 3'd4,
    REG_BOX_HI_Z = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] end_z;
  } lbc_in_t;

  typedef struct packed {
    logic signed [31:0] clip_start_x;
    logic signed [31:0] clip_start_y;
    logic signed [31:0] clip_start_z;
    logic signed [31:0] clip_end_x;
    logic signed [31:0] clip_end_y;
    logic signed [31:0] clip_end_z;
    logic               outside;
  } lbc_out_t;

endpackage

### design/line_box_clip_3d_core.sv
// A word is registered after setup, after each divider step, then at merge, multiply and output.
// Throughput: one word per cycle while the output is not stalled; six 17-stage restoring dividers set the depth.
// A stalled output freezes the whole pipeline, so no word is lost or repeated.
// Reset clears all valid bits and loads the box to the full coordinate range.
// Depends on lbc3d_pkg.
module line_box_clip_3d_core
  import lbc3d_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  lbc_in_t     in_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output lbc_out_t    out_word_o
);

  typedef struct packed {
    logic             miss;
    logic [2:0]       act;
    logic [2:0][31:0] st;
    logic [2:0][31:0] ed;
    logic [2:0][32:0] dd;
    logic [2:0][32:0] den;
    logic [5:0][33:0] rem;
    logic [5:0][16:0] quo;
  } div_t;

  typedef struct packed {
    logic             miss;
    logic [2:0][31:0] st;
    logic [2:0][31:0] ed;
    logic [2:0][32:0] dd;
    logic [16:0]      tin;
    logic [16:0]      tout;
  } par_t;

  typedef struct packed {
    logic             miss;
    logic [2:0][31:0] st;
    logic [2:0][31:0] ed;
    logic [5:0][50:0] prod;
  } mul_t;

  logic [2:0][31:0] box_lo_q, box_hi_q;
  div_t             setup_d;
  div_t             pipe_q [0:NumDivSteps];
  div_t             pipe_d [0:NumDivSteps];
  logic [NumDivSteps:0] pv_q;
  par_t             c_q, c_d;
  logic             cv_q;
  mul_t             m_q, m_d;
  logic             mv_q;
  lbc_out_t         out_q, out_d;
  logic             out_valid_q;
  logic             adv;

  function automatic div_t div_step(input div_t x, input logic first);
    div_t        y;
    logic [33:0] r;
    logic [33:0] dn;
    y = x;
    for (int j = 0; j < 6; j++) begin
      dn = {1'b0, x.den[j / 2]};
      r  = first ? x.rem[j] : {x.rem[j][32:0], 1'b0};
      if (r >= dn) begin
        y.rem[j] = r - dn;
        y.quo[j] = {x.quo[j][15:0], 1'b1};
      end else begin
        y.rem[j] = r;
        y.quo[j] = {x.quo[j][15:0], 1'b0};
      end
    end
    return y;
  endfunction

  assign adv         = !(out_valid_q && out_stall_i);
  assign in_stall_o  = !adv;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_lo_q <= {3{32'h8000_0000}};
      box_hi_q <= {3{32'h7FFF_FFFF}};
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_BOX_LO_X: box_lo_q[0] <= cfg_data_i;
        REG_BOX_LO_Y: box_lo_q[1] <= cfg_data_i;
        REG_BOX_LO_Z: box_lo_q[2] <= cfg_data_i;
        REG_BOX_HI_X: box_hi_q[0] <= cfg_data_i;
        REG_BOX_HI_Y: box_hi_q[1] <= cfg_data_i;
        REG_BOX_HI_Z: box_hi_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // axis setup: direction, quick reject, clamped numerators
  always_comb begin
    logic [2:0][31:0]   ist, ied;
    logic signed [33:0] s34, e34, lo34, hi34, d34, den34, nin, nout;
    logic               zero, pos, rej;
    ist = {in_word_i.start_z, in_word_i.start_y, in_word_i.start_x};
    ied = {in_word_i.end_z, in_word_i.end_y, in_word_i.end_x};
    setup_d = '0;
    for (int a = 0; a < NumAxes; a++) begin
      s34   = $signed({{2{ist[a][31]}}, ist[a]});
      e34   = $signed({{2{ied[a][31]}}, ied[a]});
      lo34  = $signed({{2{box_lo_q[a][31]}}, box_lo_q[a]});
      hi34  = $signed({{2{box_hi_q[a][31]}}, box_hi_q[a]});
      d34   = e34 - s34;
      zero  = (d34 == 34'sd0);
      pos   = !d34[33] && !zero;
      if (zero)     rej = (s34 < lo34) || (hi34 < s34);
      else if (pos) rej = (e34 < lo34) || (hi34 < s34);
      else          rej = (s34 < lo34) || (hi34 < e34);
      den34 = pos ? d34 : -d34;
      nin   = pos ? (lo34 - s34) : (s34 - hi34);
      nout  = pos ? (hi34 - s34) : (s34 - lo34);
      if (nin < 0)          nin = '0;
      else if (nin > den34) nin = den34;
      if (nout < 0)          nout = '0;
      else if (nout > den34) nout = den34;
      setup_d.miss       = setup_d.miss | rej;
      setup_d.act[a]     = !zero;
      setup_d.st[a]      = ist[a];
      setup_d.ed[a]      = ied[a];
      setup_d.dd[a]      = d34[32:0];
      setup_d.den[a]     = den34[32:0];
      setup_d.rem[2*a]   = nin;
      setup_d.rem[2*a+1] = nout;
    end
  end

  always_comb begin
    pipe_d[0] = setup_d;
    for (int s = 0; s < NumDivSteps; s++) begin
      pipe_d[s+1] = div_step(pipe_q[s], s == 0);
    end
  end

  // merge candidates into entry and exit parameters
  always_comb begin
    div_t        x;
    logic [16:0] ein;
    x = pipe_q[NumDivSteps];
    c_d.st   = x.st;
    c_d.ed   = x.ed;
    c_d.dd   = x.dd;
    c_d.tin  = '0;
    c_d.tout = TOne;
    for (int a = 0; a < NumAxes; a++) begin
      ein = x.quo[2*a] + 17'(x.rem[2*a] != '0);
      if (x.act[a]) begin
        if (ein > c_d.tin) c_d.tin = ein;
        if (x.quo[2*a+1] < c_d.tout) c_d.tout = x.quo[2*a+1];
      end
    end
    c_d.miss = x.miss | (c_d.tin >= c_d.tout);
  end

  always_comb begin
    m_d.miss = c_q.miss;
    m_d.st   = c_q.st;
    m_d.ed   = c_q.ed;
    for (int a = 0; a < NumAxes; a++) begin
      m_d.prod[2*a]   = $signed({{34{1'b0}}, c_q.tin}) *
                        $signed({{18{c_q.dd[a][32]}}, c_q.dd[a]});
      m_d.prod[2*a+1] = $signed({{34{1'b0}}, c_q.tout}) *
                        $signed({{18{c_q.dd[a][32]}}, c_q.dd[a]});
    end
  end

  always_comb begin
    logic [5:0][31:0] pt;
    logic [50:0]      sum;
    for (int j = 0; j < 6; j++) begin
      sum   = m_q.prod[j] + 51'd32768;
      pt[j] = m_q.st[j / 2] + sum[47:16];
    end
    out_d.outside = m_q.miss;
    if (m_q.miss) begin
      out_d.clip_start_x = m_q.st[0];
      out_d.clip_start_y = m_q.st[1];
      out_d.clip_start_z = m_q.st[2];
      out_d.clip_end_x   = m_q.ed[0];
      out_d.clip_end_y   = m_q.ed[1];
      out_d.clip_end_z   = m_q.ed[2];
    end else begin
      out_d.clip_start_x = pt[0];
      out_d.clip_start_y = pt[2];
      out_d.clip_start_z = pt[4];
      out_d.clip_end_x   = pt[1];
      out_d.clip_end_y   = pt[3];
      out_d.clip_end_z   = pt[5];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q        <= '0;
      cv_q        <= 1'b0;
      mv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      pv_q        <= {pv_q[NumDivSteps-1:0], in_valid_i};
      cv_q        <= pv_q[NumDivSteps];
      mv_q        <= cv_q;
      out_valid_q <= mv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int s = 0; s <= NumDivSteps; s++) begin
        pipe_q[s] <= pipe_d[s];
      end
      c_q   <= c_d;
      m_q   <= m_d;
      out_q <= out_d;
    end
  end

endmodule

### verif/line_box_clip_3d_core_test.sv
// Testbench for line_box_clip_3d_core: drives segments, predicts clipped endpoints.
// Self-checking against an in-bench slab clipper; depends on lbc3d_pkg and the core RTL.
`timescale 1ns / 100ps

module line_box_clip_3d_core_test;
  import lbc3d_pkg::*;

  localparam int Latency  = 20;
  localparam int WdogMax  = 20000;
  localparam longint TOneL = 65536;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  lbc_in_t     in_word_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  lbc_out_t    out_word_o;

  line_box_clip_3d_core i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  longint   box_lo [3];
  longint   box_hi [3];
  lbc_out_t clip_q[$];
  int       n_err, n_sent, n_got, n_outside, wdog;
  bit       hold_off;

  function automatic longint floor_div(longint n, longint den);
    longint q;
    q = n / den;
    if ((n % den) != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic longint ceil_div(longint n, longint den);
    longint q;
    q = n / den;
    if ((n % den) != 0 && n > 0) q++;
    return q;
  endfunction

  function automatic logic [31:0] lerp(longint st, longint ed, longint t);
    longint p;
    p = st + floor_div(t * (ed - st) + TOneL / 2, TOneL);
    return p[31:0];
  endfunction

  function automatic lbc_out_t clip_segment(lbc_in_t w);
    longint st[3], ed[3];
    longint t_in, t_out, d, den, n_in, n_out, c;
    bit miss;
    lbc_out_t r;
    st[0] = w.start_x; st[1] = w.start_y; st[2] = w.start_z;
    ed[0] = w.end_x;   ed[1] = w.end_y;   ed[2] = w.end_z;
    t_in = 0; t_out = TOneL; miss = 0;
    for (int a = 0; a < 3 && !miss; a++) begin
      d = ed[a] - st[a];
      if (d == 0) begin
        miss = (st[a] < box_lo[a]) || (box_hi[a] < st[a]);
      end else begin
        if (d > 0) begin
          miss = (ed[a] < box_lo[a]) || (box_hi[a] < st[a]);
          den = d; n_in = box_lo[a] - st[a]; n_out = box_hi[a] - st[a];
        end else begin
          miss = (st[a] < box_lo[a]) || (box_hi[a] < ed[a]);
          den = -d; n_in = st[a] - box_hi[a]; n_out = st[a] - box_lo[a];
        end
        if (!miss) begin
          c = ceil_div(n_in * TOneL, den);
          if (c > t_in) t_in = c;
          c = floor_div(n_out * TOneL, den);
          if (c < t_out) t_out = c;
        end
      end
    end
    if (!miss && t_in >= t_out) miss = 1;
    if (miss) begin
      r.clip_start_x = w.start_x; r.clip_start_y = w.start_y; r.clip_start_z = w.start_z;
      r.clip_end_x = w.end_x;     r.clip_end_y = w.end_y;     r.clip_end_z = w.end_z;
    end else begin
      r.clip_start_x = lerp(st[0], ed[0], t_in);
      r.clip_start_y = lerp(st[1], ed[1], t_in);
      r.clip_start_z = lerp(st[2], ed[2], t_in);
      r.clip_end_x = lerp(st[0], ed[0], t_out);
      r.clip_end_y = lerp(st[1], ed[1], t_out);
      r.clip_end_z = lerp(st[2], ed[2], t_out);
    end
    r.outside = miss;
    return r;
  endfunction

  task automatic write_box(cfg_reg_e idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx <= REG_BOX_LO_Z) box_lo[idx] = $signed(val);
    else box_hi[idx - REG_BOX_HI_X] = $signed(val);
  endtask

  task automatic set_box(logic [31:0] lx, ly, lz, hx, hy, hz);
    write_box(REG_BOX_LO_X, lx); write_box(REG_BOX_LO_Y, ly);
    write_box(REG_BOX_LO_Z, lz); write_box(REG_BOX_HI_X, hx);
    write_box(REG_BOX_HI_Y, hy); write_box(REG_BOX_HI_Z, hz);
  endtask

  task automatic write_bad_index();
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= 3'd6 + 3'($urandom_range(0, 1));
    cfg_data_i  <= $urandom;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // hold valid after the accept; the next caller drops or replaces it in the same step
  task automatic send_segment(lbc_in_t w, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    clip_q = {clip_q, clip_segment(w)};
    n_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (clip_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 5) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      lbc_out_t e;
      if (clip_q.size() == 0) begin
        $error("result with no expectation: %p", out_word_o);
        n_err++;
      end else begin
        e = clip_q.pop_front();
        n_got++;
        if (e.outside) n_outside++;
        if (out_word_o.clip_start_x !== e.clip_start_x) begin
          $error("clip_start_x exp %0d got %0d", e.clip_start_x, out_word_o.clip_start_x);
          n_err++;
        end
        if (out_word_o.clip_start_y !== e.clip_start_y) begin
          $error("clip_start_y exp %0d got %0d", e.clip_start_y, out_word_o.clip_start_y);
          n_err++;
        end
        if (out_word_o.clip_start_z !== e.clip_start_z) begin
          $error("clip_start_z exp %0d got %0d", e.clip_start_z, out_word_o.clip_start_z);
          n_err++;
        end
        if (out_word_o.clip_end_x !== e.clip_end_x) begin
          $error("clip_end_x exp %0d got %0d", e.clip_end_x, out_word_o.clip_end_x);
          n_err++;
        end
        if (out_word_o.clip_end_y !== e.clip_end_y) begin
          $error("clip_end_y exp %0d got %0d", e.clip_end_y, out_word_o.clip_end_y);
          n_err++;
        end
        if (out_word_o.clip_end_z !== e.clip_end_z) begin
          $error("clip_end_z exp %0d got %0d", e.clip_end_z, out_word_o.clip_end_z);
          n_err++;
        end
        if (out_word_o.outside !== e.outside) begin
          $error("outside exp %0b got %0b", e.outside, out_word_o.outside);
          n_err++;
        end
      end
    end
  end

  // receiver stall: random per word, or a long hold-off when asked
  initial begin
    int w;
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        out_stall_i <= 1'b1;
        repeat (300) @(posedge clk_i);
        hold_off = 0;
        out_stall_i <= 1'b0;
      end else if (out_valid_o && !out_stall_i) begin
        w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
        if (w > 0) begin
          out_stall_i <= 1'b1;
          repeat (w) @(posedge clk_i);
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o))
      wdog <= 0;
    else
      wdog <= wdog + 1;
    if (wdog > WdogMax) begin
      $display("line_box_clip_3d_core_test: errors");
      $finish;
    end
  end

  function automatic logic [31:0] rnd_coord(logic [31:0] lo, logic [31:0] hi);
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
      default: return 32'($signed(lo) +
                          ($urandom % (longint'($signed(hi)) - $signed(lo) + 1)));
    endcase
  endfunction

  function automatic lbc_in_t rnd_segment();
    lbc_in_t w;
    w.start_x = rnd_coord(32'hfff0_0000, 32'h0010_0000);
    w.start_y = rnd_coord(32'hfff0_0000, 32'h0010_0000);
    w.start_z = rnd_coord(32'hfff0_0000, 32'h0010_0000);
    w.end_x = rnd_coord(32'hfff0_0000, 32'h0010_0000);
    w.end_y = rnd_coord(32'hfff0_0000, 32'h0010_0000);
    w.end_z = rnd_coord(32'hfff0_0000, 32'h0010_0000);
    case ($urandom_range(0, 7))
      0: w.end_x = w.start_x;
      1: begin w.end_y = w.start_y; w.end_z = w.start_z; end
      2: w[95:0] = w[191:96];
      default: ;
    endcase
    return w;
  endfunction

  task automatic test_directed();
    lbc_in_t w;
    set_box(32'hfffe_0000, 32'hfffe_0000, 32'hfffe_0000,
            32'h0002_0000, 32'h0002_0000, 32'h0002_0000);
    write_bad_index();
    w = '{32'hfffc_0000, 0, 0, 32'h0004_0000, 0, 0};                send_segment(w);
    w = '{32'h0004_0000, 32'h0001_0000, 0, 32'hfffc_0000, 0, 0};    send_segment(w);
    w = '{0, 0, 0, 0, 0, 0};                                        send_segment(w);
    w = '{32'h0003_0000, 0, 0, 32'h0003_0000, 0, 0};                send_segment(w);
    w = '{32'h0003_0000, 0, 0, 32'h0005_0000, 0, 0};                send_segment(w);
    w = '{32'hfffc_0000, 32'h0004_0000, 0, 32'h0004_0000, 32'hfffc_0000, 0};
    send_segment(w);
    w = '{32'hfffc_0000, 32'h0003_0000, 0, 32'h0000_0000, 32'h0007_0000, 0};
    send_segment(w);
    w = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
          32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};             send_segment(w);
    w = '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
          32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000};             send_segment(w);
    w = '{32'hfffe_0000, 0, 0, 32'h0002_0000, 0, 0};                send_segment(w);
    w = '{32'h0000_0001, 32'hffff_ffff, 5, 32'h0001_2345, 32'hfffe_dcba, 32'h0000_7777};
    send_segment(w);
    drain();
    // inverted box on y
    set_box(32'hfffe_0000, 32'h0002_0000, 32'hfffe_0000,
            32'h0002_0000, 32'hfffe_0000, 32'h0002_0000);
    w = '{0, 0, 0, 32'h0001_0000, 0, 0};                            send_segment(w);
    w = '{0, 0, 0, 0, 0, 0};                                        send_segment(w);
    drain();
    set_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    w = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
          32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};             send_segment(w);
    w = '{32'h7fff_ffff, 0, 32'h8000_0000, 32'h8000_0000, 32'hffff_ffff, 32'h7fff_ffff};
    send_segment(w);
    drain();
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 400 == 0) begin
        drain();
        if ($urandom_range(0, 3) == 0)
          set_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        else
          set_box(32'hfff0_0000 + $urandom_range(0, 32'h000f_ffff),
                  32'hfff0_0000 + $urandom_range(0, 32'h000f_ffff),
                  32'hfff0_0000 + $urandom_range(0, 32'h000f_ffff),
                  $urandom_range(0, 32'h0010_0000), $urandom_range(0, 32'h0010_0000),
                  $urandom_range(0, 32'h0010_0000));
      end
      send_segment(rnd_segment(), (i % 100) < 15);
    end
    drain();
  endtask

  task automatic test_backpressure();
    hold_off = 1;
    for (int i = 0; i < 60; i++) send_segment(rnd_segment(), 1);
    drain();
  endtask

  initial begin
    n_err = 0; n_sent = 0; n_got = 0; n_outside = 0; wdog = 0; hold_off = 0;
    box_lo = '{-64'sd2147483648, -64'sd2147483648, -64'sd2147483648};
    box_hi = '{64'sd2147483647, 64'sd2147483647, 64'sd2147483647};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random(1850);
    $display("Sent %0d segments, checked %0d results (%0d outside) over several boxes,",
             n_sent, n_got, n_outside);
    $display("including inverted and full-range boxes and a long output hold-off.");
    if (n_err == 0 && clip_q.size() == 0)
      $display("line_box_clip_3d_core_test: clean");
    else
      $display("line_box_clip_3d_core_test: errors");
    $finish;
  end

endmodule

### files.f
design/lbc3d_pkg.sv
design/line_box_clip_3d_core.sv
verif/line_box_clip_3d_core_test.sv
